// ===== hdl/hfas_pkg.sv =====
// hfas_pkg: shared types and constants for the half-precision add/subtract block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package hfas_pkg;
  localparam int unsigned ExpBits  = 5;

  // classified operation handed from front to back
  typedef struct packed {
    logic              sign;      // sign of sum
    logic              is_zero;   // sum was zero
    logic [11:0]       mag;       // magnitude of significand sum
    logic [ExpBits:0]  exp;       // larger exponent, zero-extended
  } op_t;
endpackage
`default_nettype wire

// ===== hdl/half_float_add_sub.sv =====
// half_float_add_sub: top level of the half-precision add/subtract block
// depends on hfas_pkg, hfas_front, hfas_queue, hfas_back
//
// usage:
// - input channel: valid_i, stall_o, command_i (0 add, 1 subtract),
//   operand_a_i, operand_b_i; a beat moves when valid_i is high and stall_o low
// - output channel: valid_o, stall_i, result_o, exponent_out_of_range_o
// - one beat per cycle sustained while stall_i is low; an input beat passes the
//   front register, the queue and the back register before output valid
// - front aligns and adds significands, a two-entry queue decouples it from
//   the back, which normalizes and packs
// - when stall_i holds, the back keeps its result, the queue fills and then
//   the front register stalls; stall_o rises once all of them are full
// - reset clears every valid flag; nothing is in flight afterwards
// - no rounding, exponent wraps modulo 32 and is flagged when it does
`timescale 1ns / 1ps
`default_nettype none
module half_float_add_sub (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic        command_i,
  input  wire logic [15:0] operand_a_i,
  input  wire logic [15:0] operand_b_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [15:0]      result_o,
  output logic             exponent_out_of_range_o
);
  // front to queue
  logic          f_valid, f_stall;
  hfas_pkg::op_t f_op;
  // queue to back
  logic          q_valid, q_stall;
  hfas_pkg::op_t q_op;

  hfas_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .command_i, .operand_a_i, .operand_b_i,
    .valid_o(f_valid), .stall_i(f_stall), .op_o(f_op)
  );

  hfas_queue u_queue (
    .clk_i, .rst_ni, .valid_i(f_valid), .stall_o(f_stall), .op_i(f_op),
    .valid_o(q_valid), .stall_i(q_stall), .op_o(q_op)
  );

  hfas_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .stall_o(q_stall), .op_i(q_op),
    .valid_o, .stall_i, .result_o, .exponent_out_of_range_o
  );

  // a zero sum must always pack to a zero word with no flag
  ap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !q_stall && q_op.is_zero) |=> (result_o == 16'h0000 &&
    !exponent_out_of_range_o)) else $error("zero sum not packed as zero");
  // stalled output holds its beat
  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(result_o)))
    else $error("output beat changed under stall");
  // input stall only while the front holds a beat the queue cannot take
  ap_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (f_valid && f_stall)) else $error("input stalled with room in the queue");
endmodule
`default_nettype wire

// ===== hdl/hfas_front.sv =====
// hfas_front: accepts operands, aligns and adds significands
// depends on hfas_pkg
`timescale 1ns / 1ps
`default_nettype none
module hfas_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic        command_i,
  input  wire logic [15:0] operand_a_i,
  input  wire logic [15:0] operand_b_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output hfas_pkg::op_t    op_o
);
  logic        valid_q;
  hfas_pkg::op_t op_q, op_d;
  logic [15:0] b;
  logic [4:0]  ea, eb, d;
  logic signed [12:0] va, vb, sa, sb, sum;
  logic        a_big;

  always_comb begin
    b = operand_b_i;
    if (command_i && (operand_b_i != 16'h0000)) b[15] = ~b[15];
    ea = operand_a_i[14:10];
    eb = b[14:10];
    va = {2'b00, 1'b1, operand_a_i[9:0]};
    vb = {2'b00, 1'b1, b[9:0]};
    if (operand_a_i[15]) va = -va;
    if (b[15]) vb = -vb;
    a_big = ea > eb;
    d = a_big ? (ea - eb) : (eb - ea);
    sa = va;
    sb = vb;
    if (a_big) sb = vb >>> d;
    else       sa = va >>> d;
    sum = sa + sb;
    op_d.sign    = sum[12];
    op_d.is_zero = (sum == 13'sd0);
    op_d.mag     = sum[12] ? 12'(-sum) : sum[11:0];
    op_d.exp     = {1'b0, a_big ? ea : eb};
  end

  assign stall_o = valid_q && stall_i;
  assign valid_o = valid_q;
  assign op_o    = op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      op_q <= op_d;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/hfas_queue.sv =====
// hfas_queue: two-entry skid queue between front and back
// depends on hfas_pkg
`timescale 1ns / 1ps
`default_nettype none
module hfas_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               stall_o,
  input  hfas_pkg::op_t      op_i,
  output logic               valid_o,
  input  wire logic          stall_i,
  output hfas_pkg::op_t      op_o
);
  hfas_pkg::op_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign stall_o = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign op_o    = mem_q[rd_q];
  assign push    = valid_i && !stall_o;
  assign pop     = valid_o && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= op_i;
  end

  ap_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  ap_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2) else $error("full queue lost entry");
  ap_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 && !valid_i) |=> cnt_q == 2'd0) else $error("empty queue gained entry");
endmodule
`default_nettype wire

// ===== hdl/hfas_back.sv =====
// hfas_back: normalizes and packs the sum into a half-precision word
// depends on hfas_pkg
`timescale 1ns / 1ps
`default_nettype none
module hfas_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  hfas_pkg::op_t    op_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [15:0]      result_o,
  output logic             exponent_out_of_range_o
);
  logic        valid_q;
  logic [15:0] res_q, res_d;
  logic        oor_q, oor_d;
  logic [3:0]  p;
  logic [11:0] m;
  logic signed [7:0] e;

  always_comb begin
    p = 4'd0;
    for (int i = 0; i < 12; i++) if (op_i.mag[i]) p = 4'(i);
    m = op_i.mag;
    e = 8'(signed'({2'b00, op_i.exp}));
    if (p < 4'd10) begin
      m = op_i.mag << (4'd10 - p);
      e = e - 8'(4'd10 - p);
    end else if (p > 4'd10) begin
      m = op_i.mag >> (p - 4'd10);
      e = e + 8'(p - 4'd10);
    end
    if (op_i.is_zero) begin
      res_d = 16'h0000;
      oor_d = 1'b0;
    end else begin
      res_d = {op_i.sign, e[4:0], m[9:0]};
      oor_d = (e < 0) || (e > 8'sd31);
    end
  end

  assign stall_o = valid_q && stall_i;
  assign valid_o = valid_q;
  assign result_o = res_q;
  assign exponent_out_of_range_o = oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      res_q <= res_d;
      oor_q <= oor_d;
    end
  end
endmodule
`default_nettype wire

// ===== tb/half_float_add_sub_test.sv =====
// half_float_add_sub_test: self-checking testbench for the half-precision add/subtract block
// depends on half_float_add_sub; predicts each beat in a small scoreboard class
`timescale 1ns / 1ps
`default_nettype none
module half_float_add_sub_test;

  localparam logic CmdAdd = 1'b0;
  localparam logic CmdSub = 1'b1;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [15:0] word;
    logic        oor;
  } sum_t;

  // expected sums and the checker against them
  class sum_board;
    sum_t pending[$];
    int   mismatches;

    function automatic int signed signif(logic [15:0] w);
      int signed m;
      m = int'({1'b1, w[9:0]});
      return w[15] ? -m : m;
    endfunction

    function automatic sum_t add_halves(logic cmd, logic [15:0] a, logic [15:0] b);
      int signed ea, eb, va, vb, e, s, mag, p, d;
      sum_t r;
      if (cmd == CmdSub && b != 16'h0000) b[15] = ~b[15];
      ea = int'(a[14:10]);
      eb = int'(b[14:10]);
      va = signif(a);
      vb = signif(b);
      // align the smaller exponent; arithmetic shift floors
      if (ea > eb) begin
        d = ea - eb;
        vb = vb >>> (d > 20 ? 20 : d);
        e = ea;
      end else begin
        d = eb - ea;
        va = va >>> (d > 20 ? 20 : d);
        e = eb;
      end
      s = va + vb;
      if (s == 0) return '0;
      mag = s < 0 ? -s : s;
      p = 0;
      for (int i = 0; i < 16; i++) if (mag[i]) p = i;
      if (p < 10) begin
        mag = mag << (10 - p);
        e -= 10 - p;
      end else if (p > 10) begin
        mag = mag >> (p - 10);
        e += p - 10;
      end
      r.word = {s < 0 ? 1'b1 : 1'b0, e[4:0], mag[9:0]};
      r.oor = (e < 0) || (e > 31);
      return r;
    endfunction

    function void note_operands(logic cmd, logic [15:0] a, logic [15:0] b);
      pending.push_back(add_halves(cmd, a, b));
    endfunction

    function void check_sum(logic [15:0] word, logic oor);
      sum_t x;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", word);
        return;
      end
      x = pending.pop_front();
      if (x.word !== word || x.oor !== oor) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h/%b actual %h/%b", x.word, x.oor, word, oor);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic        command_i = 1'b0;
  logic [15:0] operand_a_i = '0;
  logic [15:0] operand_b_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [15:0] result_o;
  logic        exponent_out_of_range_o;

  sum_board board = new();
  int   cycles = 0;
  bit   calm = 1'b0;   // no idling on either side while set

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  half_float_add_sub uut (.*);

  // result side: sample at the edge, random stall
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (valid_o && !stall_i) board.check_sum(result_o, exponent_out_of_range_o);
      stall_i <= calm ? 1'b0 : ($urandom_range(99) < 10);
    end
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // present one beat, optionally idle first, wait until it is taken
  task automatic send_beat(logic cmd, logic [15:0] a, logic [15:0] b);
    if (!calm && $urandom_range(99) < 10) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    command_i <= cmd;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    board.note_operands(cmd, a, b);
  endtask

  task automatic drain;
    valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  // mostly nearby exponents so sums cancel and normalize often
  function automatic logic [15:0] near_word(logic [15:0] a);
    logic [15:0] w;
    w = 16'($urandom);
    if ($urandom_range(3) != 0)
      w[14:10] = 5'(int'(a[14:10]) + $urandom_range(4) - 2);
    if ($urandom_range(7) == 0) w[9:0] = a[9:0];
    return w;
  endfunction

  initial begin
    logic [15:0] a;
    logic [15:0] directed[10];
    directed = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h3C00,
                 16'hBC00, 16'h03FF, 16'h7C00, 16'h0400, 16'h83FF};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, zero-word subtract, cancellation, huge exponent gaps, wrap
    for (int i = 0; i < 10; i++)
      send_beat(i[0] ? CmdSub : CmdAdd, directed[i], directed[(i * 3 + 1) % 10]);
    send_beat(CmdSub, 16'h3C00, 16'h3C00);
    send_beat(CmdAdd, 16'h3C00, 16'hBC00);
    send_beat(CmdSub, 16'h1234, 16'h0000);
    send_beat(CmdSub, 16'h1234, 16'h8000);
    send_beat(CmdAdd, 16'h7FFF, 16'h7FFF);
    send_beat(CmdSub, 16'h0000, 16'h03FF);
    send_beat(CmdAdd, 16'h7C00, 16'h8000);
    send_beat(CmdAdd, 16'h7C00, 16'h0000);
    send_beat(CmdAdd, 16'hFC00, 16'h0000);
    send_beat(CmdSub, 16'h4000, 16'h3FFF);
    send_beat(CmdAdd, 16'h0000, 16'h0000);
    // sender holds off until the pipe is empty
    drain();

    for (int n = 0; n < 900; n++) begin
      calm = (n >= 300 && n < 400);
      a = 16'($urandom);
      send_beat(1'($urandom), a, $urandom_range(4) == 0 ? 16'($urandom) : near_word(a));
      if (n == 600) drain();
    end
    drain();
    repeat (10) @(posedge clk_i);

    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
